>>> design/ftpq_pkg.sv
// ftpq_pkg: shared types and constants of the flow timer priority queue
// used by the interfaces, the controller, the datapath and the top level
// no dependencies
package ftpq_pkg;

   localparam int FLOWS_DEFAULT     = 64;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int FUNC_W     = 3;
   localparam int SLOT_W     = 6;
   localparam int TICK_W     = 32;
   localparam int DEADLINE_W = 32;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_RESTART    = 3'd0,
      FUNC_STOP       = 3'd1,
      FUNC_PEEK       = 3'd2,
      FUNC_EXPIRE     = 3'd3,
      FUNC_EXPIRE_ALL = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      EMIT_BEST = 2'd0,
      EMIT_PEND = 2'd1,
      EMIT_NONE = 2'd2
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         wr_deadline;
      logic         stop;
      logic         scan_start;
      logic         scan_run;
      logic         clear_best;
      logic         hold_pend;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic qualify;
      logic out_free;
   } status_type;

endpackage

>>> design/ftpq_if.sv
// ftpq_req_if and ftpq_rsp_if: valid/ready channels of the timer queue
// depends on ftpq_pkg for field widths
interface ftpq_req_if;
   logic                          valid;
   logic                          ready;
   logic [ftpq_pkg::FUNC_W-1:0]   func;
   logic [ftpq_pkg::SLOT_W-1:0]   flow_slot;
   logic [ftpq_pkg::TICK_W-1:0]   tick_value;

   modport source (output valid, func, flow_slot, tick_value, input ready);
   modport sink   (input valid, func, flow_slot, tick_value, output ready);
endinterface

interface ftpq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [ftpq_pkg::SLOT_W-1:0]     expired_slot;
   logic [ftpq_pkg::DEADLINE_W-1:0] deadline;
   logic                            last;

   modport source (output valid, found, expired_slot, deadline, last, input ready);
   modport sink   (input valid, found, expired_slot, deadline, last, output ready);
endinterface

>>> design/ftpq_datapath.sv
// ftpq_datapath: deadline memory, active bits, minimum sweep and result register
// depends on ftpq_pkg; driven by ftpq_controller through cmd_type
module ftpq_datapath #(
   parameter int FLOWS     = ftpq_pkg::FLOWS_DEFAULT,
   parameter int TIME_BITS = ftpq_pkg::TIME_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [ftpq_pkg::SLOT_W-1:0]       req_flow_slot,
   input  logic [ftpq_pkg::TICK_W-1:0]       req_tick_value,
   input  ftpq_pkg::cmd_type                 cmd,
   output ftpq_pkg::status_type              status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [ftpq_pkg::SLOT_W-1:0]       rsp_expired_slot,
   output logic [ftpq_pkg::DEADLINE_W-1:0]   rsp_deadline,
   output logic                              rsp_last
);

   localparam int SLOT_BITS = $clog2(FLOWS);
   localparam int CNT_BITS  = $clog2(FLOWS + 1);

   logic [TIME_BITS-1:0] deadline_mem [FLOWS];
   logic [FLOWS-1:0]     active_ff;

   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 rd_hit_ff, rd_hit_in;
   logic [SLOT_BITS-1:0] rd_idx_ff;
   logic [TIME_BITS-1:0] rd_data_ff;

   logic                 best_found_ff, best_found_in;
   logic [SLOT_BITS-1:0] best_idx_ff;
   logic [TIME_BITS-1:0] best_dl_ff;
   logic [TIME_BITS-1:0] tick_ff;

   logic [SLOT_BITS-1:0] pend_idx_ff;
   logic [TIME_BITS-1:0] pend_dl_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff;
   logic [ftpq_pkg::SLOT_W-1:0]     rsp_slot_ff;
   logic [ftpq_pkg::DEADLINE_W-1:0] rsp_dl_ff;
   logic                            rsp_last_ff;

   logic                 in_range;
   logic [SLOT_BITS-1:0] wr_idx;
   logic [SLOT_BITS-1:0] scan_idx;
   logic                 issue;
   logic                 better;

   assign in_range = int'(req_flow_slot) < FLOWS;
   assign wr_idx   = req_flow_slot[SLOT_BITS-1:0];
   assign scan_idx = cnt_ff[SLOT_BITS-1:0];
   assign issue    = cmd.scan_run && (cnt_ff != CNT_BITS'(FLOWS));
   assign better   = rd_hit_ff && (!best_found_ff || (rd_data_ff < best_dl_ff));

   always_comb begin
      cnt_in        = cnt_ff;
      rd_hit_in     = 1'b0;
      best_found_in = best_found_ff;
      if (cmd.scan_start) begin
         cnt_in        = '0;
         best_found_in = 1'b0;
      end else begin
         if (issue) begin
            cnt_in    = cnt_ff + CNT_BITS'(1);
            rd_hit_in = active_ff[scan_idx];
         end
         if (better) begin
            best_found_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         cnt_ff        <= '0;
         rd_hit_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         rd_hit_ff     <= rd_hit_in;
         best_found_ff <= best_found_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cmd.wr_deadline && in_range) begin
            active_ff[wr_idx] <= 1'b1;
         end
         if (cmd.stop && in_range) begin
            active_ff[wr_idx] <= 1'b0;
         end
         if (cmd.clear_best && best_found_ff) begin
            active_ff[best_idx_ff] <= 1'b0;
         end
      end
   end

   // deadline memory
   always_ff @(posedge clock) begin
      if (cmd.wr_deadline && in_range) begin
         deadline_mem[wr_idx] <= TIME_BITS'(req_tick_value);
      end
      if (issue) begin
         rd_data_ff <= deadline_mem[scan_idx];
         rd_idx_ff  <= scan_idx;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tick_ff <= TIME_BITS'(req_tick_value);
      end
      if (!cmd.scan_start && better) begin
         best_idx_ff <= rd_idx_ff;
         best_dl_ff  <= rd_data_ff;
      end
      if (cmd.hold_pend) begin
         pend_idx_ff <= best_idx_ff;
         pend_dl_ff  <= best_dl_ff;
      end
      if (cmd.emit) begin
         case (cmd.emit_sel)
            ftpq_pkg::EMIT_BEST: begin
               rsp_found_ff <= best_found_ff;
               rsp_slot_ff  <= best_found_ff ? ftpq_pkg::SLOT_W'(best_idx_ff) : '0;
               rsp_dl_ff    <= best_found_ff ? ftpq_pkg::DEADLINE_W'(best_dl_ff) : '0;
               rsp_last_ff  <= 1'b1;
            end
            ftpq_pkg::EMIT_PEND: begin
               rsp_found_ff <= 1'b1;
               rsp_slot_ff  <= ftpq_pkg::SLOT_W'(pend_idx_ff);
               rsp_dl_ff    <= ftpq_pkg::DEADLINE_W'(pend_dl_ff);
               rsp_last_ff  <= cmd.emit_last;
            end
            default: begin
               rsp_found_ff <= 1'b0;
               rsp_slot_ff  <= '0;
               rsp_dl_ff    <= '0;
               rsp_last_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign status.scan_done = (cnt_ff == CNT_BITS'(FLOWS)) && !rd_hit_ff;
   assign status.qualify   = best_found_ff && (best_dl_ff < tick_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_expired_slot = rsp_slot_ff;
   assign rsp_deadline     = rsp_dl_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

>>> design/ftpq_controller.sv
// ftpq_controller: state machine sequencing writes, sweeps and result transfers
// depends on ftpq_pkg; drives ftpq_datapath through cmd_type
module ftpq_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [ftpq_pkg::FUNC_W-1:0]   req_func,
   output logic                          req_ready,
   input  ftpq_pkg::status_type          status,
   output ftpq_pkg::cmd_type             cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff, state_in;
   ftpq_pkg::func_type func_ff, func_in;
   logic               pend_ff, pend_in;
   logic               accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      cmd.emit_sel = ftpq_pkg::EMIT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               func_in  = ftpq_pkg::func_type'(req_func);
               pend_in  = 1'b0;
               unique case (ftpq_pkg::func_type'(req_func)) inside
                  ftpq_pkg::FUNC_RESTART: cmd.wr_deadline = 1'b1;
                  ftpq_pkg::FUNC_STOP:    cmd.stop = 1'b1;
                  ftpq_pkg::FUNC_PEEK, ftpq_pkg::FUNC_EXPIRE,
                  ftpq_pkg::FUNC_EXPIRE_ALL: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (func_ff == ftpq_pkg::FUNC_EXPIRE_ALL) begin
               if (status.qualify && !pend_ff) begin
                  cmd.clear_best = 1'b1;
                  cmd.hold_pend  = 1'b1;
                  cmd.scan_start = 1'b1;
                  pend_in        = 1'b1;
                  state_in       = ST_SCAN;
               end else if (status.out_free) begin
                  if (status.qualify) begin
                     // earlier flow goes out, this one waits for the next sweep
                     cmd.emit       = 1'b1;
                     cmd.emit_sel   = ftpq_pkg::EMIT_PEND;
                     cmd.emit_last  = 1'b0;
                     cmd.clear_best = 1'b1;
                     cmd.hold_pend  = 1'b1;
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end else if (pend_ff) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_sel  = ftpq_pkg::EMIT_PEND;
                     cmd.emit_last = 1'b1;
                     pend_in       = 1'b0;
                     state_in      = ST_IDLE;
                  end else begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = ftpq_pkg::EMIT_NONE;
                     state_in     = ST_IDLE;
                  end
               end
            end else if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_sel   = ftpq_pkg::EMIT_BEST;
               cmd.clear_best = (func_ff == ftpq_pkg::FUNC_EXPIRE);
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         func_ff  <= ftpq_pkg::FUNC_RESTART;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

>>> design/flow_timer_priority_queue_core.sv
// Flow timer priority queue: one deadline and one active bit per flow slot. Restart,
// stop and unused function codes are done when accepted, without leaving the idle state.
// Peek and expire each run one sweep that reads one deadline memory entry per cycle
// to find the earliest active deadline (lowest slot on ties). Expire-all runs one
// sweep per expired flow plus a final one, and each result transfer holds the result
// until it is taken. A new request is taken once the last result is in the output
// register.
module flow_timer_priority_queue_core #(
   parameter int FLOWS     = ftpq_pkg::FLOWS_DEFAULT,
   parameter int TIME_BITS = ftpq_pkg::TIME_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   ftpq_req_if.sink     req,
   ftpq_rsp_if.source   rsp
);

   ftpq_pkg::cmd_type    cmd;
   ftpq_pkg::status_type status;

   ftpq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_func  (req.func),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ftpq_datapath #(
      .FLOWS     (FLOWS),
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_flow_slot    (req.flow_slot),
      .req_tick_value   (req.tick_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp.ready),
      .rsp_valid        (rsp.valid),
      .rsp_found        (rsp.found),
      .rsp_expired_slot (rsp.expired_slot),
      .rsp_deadline     (rsp.deadline),
      .rsp_last         (rsp.last)
   );

   // a result is loaded only when the output register is free
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result loaded over an untaken transfer");

   // only a qualifying flow becomes the pending result
   a_pend_qualify: assert property (@(posedge clock) disable iff (reset)
      cmd.hold_pend |-> (status.qualify && cmd.clear_best))
      else $error("pending result taken without a qualifying flow");

   // no request is taken during a sweep
   a_no_accept_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_run |-> !req.ready)
      else $error("request accepted during a sweep");

endmodule
